[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(name, clk, rst, cond, msg)
`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/tlbpt_pkg.sv]
package tlbpt_pkg;

  localparam int PAGE_BITS   = 8;
  localparam int OFFSET_BITS = 8;
  localparam int FRAME_BITS  = 8;
  localparam int COUNT_BITS  = 32;
  localparam int PAGE_SPACE  = 256;

  localparam logic [FRAME_BITS:0]   FRAME_LIMIT = 9'd256;
  localparam logic [FRAME_BITS-1:0] LAST_FRAME  = 8'hFF;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_MAP_READ,
    ST_MAP_USE,
    ST_DONE
  } tpt_state_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

[rtl/tlb_page_table_translator_top.sv]
// A word is accepted in idle, then the whole TLB memory is scanned; a TLB hit goes straight
// to the output, while a miss reads the page map, maps the page to a new frame if it was
// unmapped and fills a TLB entry. A new word is accepted only after the last one is loaded
// into the output register. The single tag comparator walks the TLB memory one entry a cycle.
// Reset (rst, synchronous) empties the TLB and page map at once; no clearing pass.
`include "assert_macros.svh"

module tlb_page_table_translator_top #(
  parameter int TLB_ENTRIES = 16,
  parameter int PAGE_COUNT  = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] logical_address
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [15:0] physical_address, [47:16] hit_count,
                                      // [79:48] fault_count
  output logic [1:0]  m_axis_tuser    // [0] tlb_hit, [1] page_fault
);

  localparam int IDX_W     = $clog2(TLB_ENTRIES);
  localparam int MAP_DEPTH = (PAGE_COUNT < tlbpt_pkg::PAGE_SPACE) ? PAGE_COUNT
                                                                   : tlbpt_pkg::PAGE_SPACE;
  localparam int MAP_W     = $clog2(MAP_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);
  localparam logic [11:0] PAGE_MOD = 12'(PAGE_COUNT);

  tlbpt_pkg::tpt_state_t state, state_next;

  logic [tlbpt_pkg::PAGE_BITS-1:0]   page;
  logic [tlbpt_pkg::OFFSET_BITS-1:0] offset;
  logic [tlbpt_pkg::FRAME_BITS-1:0]  frame;
  logic                              hit;
  logic                              fault;
  logic [tlbpt_pkg::COUNT_BITS-1:0]  hit_counter;
  logic [tlbpt_pkg::COUNT_BITS-1:0]  fault_counter;
  logic [tlbpt_pkg::FRAME_BITS:0]    next_free_frame;
  logic [IDX_W-1:0]                  fill_ptr;
  logic [IDX_W-1:0]                  scan_idx;
  logic                              rd_go;

  logic [TLB_ENTRIES-1:0] tlb_valid;
  logic [15:0]            tlb_mem [TLB_ENTRIES];
  logic [tlbpt_pkg::PAGE_BITS-1:0]  tlb_rd_tag;
  logic [tlbpt_pkg::FRAME_BITS-1:0] tlb_rd_frame;
  logic                             tlb_rd_valid;

  logic [MAP_DEPTH-1:0]             map_valid;
  logic [tlbpt_pkg::FRAME_BITS-1:0] map_mem [MAP_DEPTH];
  logic [tlbpt_pkg::FRAME_BITS-1:0] map_rd_frame;
  logic                             map_rd_mapped;

  logic                             match;
  logic                             hit_now;
  logic                             load_out;
  logic [MAP_W-1:0]                 map_idx;
  logic [11:0]                      page_rem;
  logic [tlbpt_pkg::FRAME_BITS-1:0] alloc_frame;
  logic [tlbpt_pkg::FRAME_BITS-1:0] miss_frame;
  logic                             miss_we;
  logic                             map_we;

  assign match   = rd_go && tlb_rd_valid && (tlb_rd_tag == page);
  assign hit_now = hit || match;

  // reduce page modulo the map depth by restoring subtraction (exact for PAGE_COUNT of 16 or more)
  always_comb begin
    page_rem = 12'(page);
    if (PAGE_COUNT < tlbpt_pkg::PAGE_SPACE) begin
      for (int k = 3; k >= 0; k--) begin
        if (page_rem >= (PAGE_MOD << k)) page_rem = page_rem - (PAGE_MOD << k);
      end
    end
  end
  assign map_idx = page_rem[MAP_W-1:0];

  assign alloc_frame = (next_free_frame < tlbpt_pkg::FRAME_LIMIT)
                     ? next_free_frame[tlbpt_pkg::FRAME_BITS-1:0] : tlbpt_pkg::LAST_FRAME;
  assign miss_frame  = map_rd_mapped ? map_rd_frame : alloc_frame;
  assign miss_we     = (state == tlbpt_pkg::ST_MAP_USE);
  assign map_we      = miss_we && !map_rd_mapped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlbpt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      tlbpt_pkg::ST_IDLE: begin
        s_axis_tready = !rst;
        if (s_axis_tvalid) state_next = tlbpt_pkg::ST_SCAN;
      end
      tlbpt_pkg::ST_SCAN: begin
        if (scan_idx == LAST_IDX) state_next = tlbpt_pkg::ST_SCAN_END;
      end
      tlbpt_pkg::ST_SCAN_END: begin
        state_next = hit_now ? tlbpt_pkg::ST_DONE : tlbpt_pkg::ST_MAP_READ;
      end
      tlbpt_pkg::ST_MAP_READ: begin
        state_next = tlbpt_pkg::ST_MAP_USE;
      end
      tlbpt_pkg::ST_MAP_USE: begin
        state_next = tlbpt_pkg::ST_DONE;
      end
      tlbpt_pkg::ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = tlbpt_pkg::ST_IDLE;
        end
      end
      default: state_next = tlbpt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_go           <= 1'b0;
      scan_idx        <= '0;
      fill_ptr        <= '0;
      next_free_frame <= '0;
      hit_counter     <= '0;
      fault_counter   <= '0;
      tlb_valid       <= '0;
      map_valid       <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      rd_go <= (state == tlbpt_pkg::ST_SCAN);
      if (state == tlbpt_pkg::ST_SCAN) begin
        scan_idx <= (scan_idx == LAST_IDX) ? '0 : scan_idx + 1'b1;
      end
      if (state == tlbpt_pkg::ST_SCAN_END && hit_now) begin
        hit_counter <= tlbpt_pkg::sat_inc(hit_counter);
      end
      if (map_we) begin
        fault_counter      <= tlbpt_pkg::sat_inc(fault_counter);
        map_valid[map_idx] <= 1'b1;
        if (next_free_frame < tlbpt_pkg::FRAME_LIMIT) next_free_frame <= next_free_frame + 1'b1;
      end
      if (miss_we) begin
        tlb_valid[fill_ptr] <= 1'b1;
        fill_ptr            <= (fill_ptr == LAST_IDX) ? '0 : fill_ptr + 1'b1;
      end
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // hold the word in flight
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      page   <= s_axis_tdata[15:8];
      offset <= s_axis_tdata[7:0];
      hit    <= 1'b0;
      fault  <= 1'b0;
      frame  <= '0;
    end else begin
      if (rd_go) begin
        hit <= hit_now;
        if (match) frame <= tlb_rd_frame;
      end
      if (state == tlbpt_pkg::ST_MAP_READ) begin
        map_rd_mapped <= map_valid[map_idx];
      end
      if (miss_we) begin
        frame <= miss_frame;
        fault <= !map_rd_mapped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (miss_we) tlb_mem[fill_ptr] <= {page, miss_frame};
    {tlb_rd_tag, tlb_rd_frame} <= tlb_mem[scan_idx];
    tlb_rd_valid <= tlb_valid[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_idx] <= alloc_frame;
    map_rd_frame <= map_mem[map_idx];
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= {fault_counter, hit_counter, frame, offset};
      m_axis_tuser <= {fault, hit};
    end
  end

  `ASSERT_IMPLIES(a_hit_xor_fault, clk, rst, m_axis_tvalid,
                  !(m_axis_tuser[0] && m_axis_tuser[1]), "hit and fault flagged together")
  `ASSERT_NEXT(a_fill_advance, clk, rst, state == tlbpt_pkg::ST_MAP_USE,
               fill_ptr != $past(fill_ptr), "fill pointer did not advance on miss")
  `ASSERT_ALWAYS(a_frame_limit, clk, rst, next_free_frame <= tlbpt_pkg::FRAME_LIMIT,
                 "free frame count beyond limit")
  `ASSERT_IMPLIES(a_fault_counted, clk, rst, m_axis_tvalid && m_axis_tuser[1],
                  m_axis_tdata[79:48] != 32'd0, "fault word with zero fault count")

endmodule
